// ===== sv/crc32_frame_receive_checker_core_defines.svh =====
// Assertion macros shared by the frame receive checker RTL.
`ifndef CRC32_FRAME_RECEIVE_CHECKER_CORE_DEFINES_SVH
`define CRC32_FRAME_RECEIVE_CHECKER_CORE_DEFINES_SVH

// The expression must hold at every clock edge outside reset.
`define CRC32FRC_ASSERT_ALWAYS(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// When the condition holds, the expression must hold in the following cycle.
`define CRC32FRC_ASSERT_NEXT(name, clk, rst_n, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== sv/crc32frc_pkg.sv =====
// Types, constants and CRC functions shared by the frame receive checker.
`timescale 1ns / 1ps

package crc32frc_pkg;

    localparam int unsigned MAX_FRAME_BYTES  = 65535;
    localparam int unsigned POS_W            = $clog2(MAX_FRAME_BYTES + 2);
    localparam int unsigned OVERHEAD_BYTES   = 10;
    localparam int unsigned RESPONSE_OFFSET  = 10;
    localparam int unsigned RESPONSE_BIT     = 7;
    localparam int unsigned SEQ_LO_OFFSET    = 2;
    localparam int unsigned SEQ_HI_OFFSET    = 3;
    localparam int unsigned CRC_START_OFFSET = 2;
    localparam int unsigned DELAY_DEPTH      = 4;
    localparam int unsigned CRC_FEED_OFFSET  = CRC_START_OFFSET + DELAY_DEPTH;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [31:0] CRC_POLY_DEFAULT = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT_DEFAULT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOR_DEFAULT  = 32'hFFFF_FFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHECK_ENABLE = 3'd0,
        CFG_POLYNOMIAL   = 3'd1,
        CFG_INITIAL      = 3'd2,
        CFG_FINAL_XOR    = 3'd3,
        CFG_REFLECT      = 3'd4
    } cfg_index_e;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_CRC_ERROR = 2'd2,
        STATUS_LONG      = 2'd3
    } frame_status_e;

    typedef enum logic [1:0] {
        LEN_VALID = 2'd0,
        LEN_SHORT = 2'd1,
        LEN_LONG  = 2'd2
    } len_class_e;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } rx_beat_t;

    typedef struct packed {
        frame_status_e frame_status;
        logic [15:0]   sequence_number;
        logic          response_frame;
        logic [15:0]   payload_length;
        logic [31:0]   frames_total;
        logic [31:0]   crc_error_total;
        logic [31:0]   lost_frames_total;
    } res_beat_t;

    typedef struct packed {
        logic        check_enable;
        logic [31:0] polynomial;
        logic [31:0] init_value;
        logic [31:0] final_xor;
        logic        refl;
    } cfg_t;

    typedef struct packed {
        len_class_e  len_class;
        logic [15:0] seq;
        logic        resp;
        logic [15:0] plen;
        logic [31:0] crc;
        logic [31:0] rx_crc;
    } frame_entry_t;

    function automatic logic [31:0] reflect32(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++)
        begin
            r[i] = v[31-i];
        end
        return r;
    endfunction

    function automatic logic [31:0] crc_feed_byte(input logic [31:0] crc,
                                                  input logic [7:0]  b,
                                                  input logic [31:0] poly,
                                                  input logic        refl);
        logic [31:0] r;
        logic [31:0] rp;
        rp = reflect32(poly);
        if (refl)
        begin
            r = crc ^ {24'd0, b};
            for (int i = 0; i < 8; i++)
            begin
                r = r[0] ? ((r >> 1) ^ rp) : (r >> 1);
            end
        end
        else
        begin
            r = crc ^ {b, 24'd0};
            for (int i = 0; i < 8; i++)
            begin
                r = r[31] ? ((r << 1) ^ poly) : (r << 1);
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/crc32_frame_receive_checker_core.sv =====
// Top level of the CRC-32 frame receive checker with sequence loss counting.
// Throughput: one byte beat per cycle while the summary queue is not full; a frame
// summary waits in a four-entry queue while the result register is stalled.
// A frame's summary is queued with its last byte, and its result beat is registered on pop.
// The byte-wide CRC update in the front end sets the clock period.
// Reset clears the position, queue, counters and result valid, and loads the
// configuration registers with their defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module crc32_frame_receive_checker_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    rx_valid,
    output logic                                    rx_stall,
    input  crc32frc_pkg::rx_beat_t                  rx_beat,
    output logic                                    res_valid,
    input  logic                                    res_stall,
    output crc32frc_pkg::res_beat_t                 res_beat,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [crc32frc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                             cfg_data
);

    crc32frc_pkg::cfg_t         cfg_reg;
    crc32frc_pkg::cfg_t         cfg_next;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_full;
    logic                       q_empty;
    crc32frc_pkg::frame_entry_t push_entry;
    crc32frc_pkg::frame_entry_t head_entry;

    always_comb
    begin
        cfg_ready = 1'b1;
        cfg_next  = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                crc32frc_pkg::CFG_CHECK_ENABLE: cfg_next.check_enable = cfg_data[0];
                crc32frc_pkg::CFG_POLYNOMIAL:   cfg_next.polynomial   = cfg_data;
                crc32frc_pkg::CFG_INITIAL:      cfg_next.init_value   = cfg_data;
                crc32frc_pkg::CFG_FINAL_XOR:    cfg_next.final_xor    = cfg_data;
                crc32frc_pkg::CFG_REFLECT:      cfg_next.refl         = cfg_data[0];
                default:                        cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_enable <= 1'b1;
            cfg_reg.polynomial   <= crc32frc_pkg::CRC_POLY_DEFAULT;
            cfg_reg.init_value   <= crc32frc_pkg::CRC_INIT_DEFAULT;
            cfg_reg.final_xor    <= crc32frc_pkg::CRC_XOR_DEFAULT;
            cfg_reg.refl         <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    crc32frc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .rx_beat  (rx_beat),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    crc32frc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head_entry (head_entry)
    );

    crc32frc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_entry   (head_entry),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

endmodule

// ===== sv/crc32frc_front.sv =====
// Front end: tracks frame position, runs the CRC and delay line, queues a summary per frame.
`timescale 1ns / 1ps
`include "crc32_frame_receive_checker_core_defines.svh"

module crc32frc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rx_valid,
    output logic                        rx_stall,
    input  crc32frc_pkg::rx_beat_t      rx_beat,
    input  crc32frc_pkg::cfg_t          cfg,
    input  logic                        q_full,
    output logic                        q_push,
    output crc32frc_pkg::frame_entry_t  q_entry
);

    localparam int unsigned POS_W = crc32frc_pkg::POS_W;
    localparam int unsigned DD    = crc32frc_pkg::DELAY_DEPTH;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [31:0]      crc_reg;
    logic [31:0]      crc_next;
    logic [7:0]       delay_reg [DD];
    logic [7:0]       delay_next [DD];
    logic [15:0]      seq_reg;
    logic [15:0]      seq_next;
    logic             resp_reg;
    logic             resp_next;

    logic             accept;
    logic             first;
    logic [31:0]      crc_cur;
    logic [7:0]       delay_cur [DD];
    logic [POS_W-1:0] len;
    logic             in_window;

    always_comb
    begin
        accept   = rx_valid && !q_full;
        rx_stall = q_full;
        first    = (pos_reg == '0);

        if (first)
        begin
            crc_cur   = cfg.refl ? crc32frc_pkg::reflect32(cfg.init_value) : cfg.init_value;
            delay_cur = '{default: '0};
            seq_next  = '0;
            resp_next = 1'b0;
        end
        else
        begin
            crc_cur   = crc_reg;
            delay_cur = delay_reg;
            seq_next  = seq_reg;
            resp_next = resp_reg;
        end

        if (pos_reg == POS_W'(crc32frc_pkg::SEQ_LO_OFFSET))
        begin
            seq_next[7:0] = rx_beat.rx_byte;
        end
        else if (pos_reg == POS_W'(crc32frc_pkg::SEQ_HI_OFFSET))
        begin
            seq_next[15:8] = rx_beat.rx_byte;
        end
        if (pos_reg == POS_W'(crc32frc_pkg::RESPONSE_OFFSET))
        begin
            resp_next = rx_beat.rx_byte[crc32frc_pkg::RESPONSE_BIT];
        end

        in_window = (pos_reg >= POS_W'(crc32frc_pkg::CRC_START_OFFSET))
                 && (pos_reg <= POS_W'(crc32frc_pkg::MAX_FRAME_BYTES));
        crc_next   = crc_cur;
        delay_next = delay_cur;
        if (in_window)
        begin
            if (pos_reg >= POS_W'(crc32frc_pkg::CRC_FEED_OFFSET))
            begin
                crc_next = crc32frc_pkg::crc_feed_byte(crc_cur, delay_cur[0],
                                                       cfg.polynomial, cfg.refl);
            end
            for (int i = 0; i < DD - 1; i++)
            begin
                delay_next[i] = delay_cur[i+1];
            end
            delay_next[DD-1] = rx_beat.rx_byte;
        end

        if (pos_reg <= POS_W'(crc32frc_pkg::MAX_FRAME_BYTES))
        begin
            len = pos_reg + POS_W'(1);
        end
        else
        begin
            len = pos_reg;
        end
        pos_next = rx_beat.end_of_frame ? '0 : len;

        q_push = accept && rx_beat.end_of_frame;
        if (len < POS_W'(crc32frc_pkg::OVERHEAD_BYTES))
        begin
            q_entry.len_class = crc32frc_pkg::LEN_SHORT;
        end
        else if (len > POS_W'(crc32frc_pkg::MAX_FRAME_BYTES))
        begin
            q_entry.len_class = crc32frc_pkg::LEN_LONG;
        end
        else
        begin
            q_entry.len_class = crc32frc_pkg::LEN_VALID;
        end
        q_entry.seq  = seq_next;
        q_entry.resp = resp_next;
        q_entry.plen = 16'(len - POS_W'(crc32frc_pkg::OVERHEAD_BYTES));
        q_entry.crc  = crc_next;
        for (int i = 0; i < DD; i++)
        begin
            q_entry.rx_crc[8*i +: 8] = delay_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            crc_reg   <= crc_next;
            delay_reg <= delay_next;
            seq_reg   <= seq_next;
            resp_reg  <= resp_next;
        end
    end

    `CRC32FRC_ASSERT_NEXT(a_pos_clears_after_last, clk, rst_n,
        rx_valid && !rx_stall && rx_beat.end_of_frame, pos_reg == '0,
        "Frame position did not return to zero after the last beat.")

endmodule

// ===== sv/crc32frc_fifo.sv =====
// Short queue of frame summaries between the front end and the back end.
`timescale 1ns / 1ps
`include "crc32_frame_receive_checker_core_defines.svh"

module crc32frc_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  crc32frc_pkg::frame_entry_t  push_entry,
    output logic                        full,
    input  logic                        pop,
    output logic                        empty,
    output crc32frc_pkg::frame_entry_t  head_entry
);

    localparam int unsigned DEPTH = crc32frc_pkg::FIFO_DEPTH;
    localparam int unsigned PTR_W = crc32frc_pkg::FIFO_PTR_W;
    localparam int unsigned CNT_W = crc32frc_pkg::FIFO_CNT_W;

    crc32frc_pkg::frame_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        full       = (count_reg == CNT_W'(DEPTH));
        empty      = (count_reg == '0);
        head_entry = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `CRC32FRC_ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && full),
        "Frame summary pushed into a full queue.")
    `CRC32FRC_ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !(pop && empty),
        "Frame summary popped from an empty queue.")

endmodule

// ===== sv/crc32frc_back.sv =====
// Back end: checks the CRC, updates the frame counters and holds the result beat.
`timescale 1ns / 1ps
`include "crc32_frame_receive_checker_core_defines.svh"

module crc32frc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  crc32frc_pkg::cfg_t          cfg,
    input  logic                        q_empty,
    input  crc32frc_pkg::frame_entry_t  q_entry,
    output logic                        q_pop,
    output logic                        res_valid,
    input  logic                        res_stall,
    output crc32frc_pkg::res_beat_t     res_beat
);

    logic                        res_valid_reg;
    crc32frc_pkg::res_beat_t     res_beat_reg;
    crc32frc_pkg::res_beat_t     res_beat_next;
    logic [31:0]                 frames_reg;
    logic [31:0]                 frames_next;
    logic [31:0]                 errors_reg;
    logic [31:0]                 errors_next;
    logic [31:0]                 lost_reg;
    logic [31:0]                 lost_next;
    logic [15:0]                 prev_seq_reg;
    logic [15:0]                 prev_seq_next;

    logic                        crc_bad;
    logic [15:0]                 gap;
    crc32frc_pkg::frame_status_e status;
    logic [15:0]                 plen;

    always_comb
    begin
        q_pop = !q_empty && (!res_valid_reg || !res_stall);

        crc_bad = cfg.check_enable && ((q_entry.crc ^ cfg.final_xor) != q_entry.rx_crc);
        gap     = 16'(q_entry.seq - prev_seq_reg - 16'd1);

        frames_next   = frames_reg;
        errors_next   = errors_reg;
        lost_next     = lost_reg;
        prev_seq_next = prev_seq_reg;
        plen          = '0;
        case (q_entry.len_class)
            crc32frc_pkg::LEN_SHORT:
            begin
                status = crc32frc_pkg::STATUS_SHORT;
            end
            crc32frc_pkg::LEN_LONG:
            begin
                status = crc32frc_pkg::STATUS_LONG;
            end
            crc32frc_pkg::LEN_VALID:
            begin
                frames_next = frames_reg + 32'd1;
                if (crc_bad)
                begin
                    status      = crc32frc_pkg::STATUS_CRC_ERROR;
                    errors_next = errors_reg + 32'd1;
                end
                else
                begin
                    status = crc32frc_pkg::STATUS_OK;
                    plen   = q_entry.plen;
                    if (!q_entry.resp)
                    begin
                        if (q_entry.seq != prev_seq_reg)
                        begin
                            lost_next = lost_reg + {16'd0, gap};
                        end
                        prev_seq_next = q_entry.seq;
                    end
                end
            end
            default:
            begin
                status = crc32frc_pkg::STATUS_SHORT;
            end
        endcase

        res_beat_next.frame_status      = status;
        res_beat_next.sequence_number   = q_entry.seq;
        res_beat_next.response_frame    = q_entry.resp;
        res_beat_next.payload_length    = plen;
        res_beat_next.frames_total      = frames_next;
        res_beat_next.crc_error_total   = errors_next;
        res_beat_next.lost_frames_total = lost_next;

        res_valid = res_valid_reg;
        res_beat  = res_beat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            frames_reg    <= '0;
            errors_reg    <= '0;
            lost_reg      <= '0;
            prev_seq_reg  <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                res_valid_reg <= 1'b1;
                frames_reg    <= frames_next;
                errors_reg    <= errors_next;
                lost_reg      <= lost_next;
                prev_seq_reg  <= prev_seq_next;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_beat_reg <= res_beat_next;
        end
    end

    `CRC32FRC_ASSERT_NEXT(a_valid_frame_counted, clk, rst_n,
        q_pop && q_entry.len_class == crc32frc_pkg::LEN_VALID,
        frames_reg == $past(frames_reg) + 32'd1,
        "Frame of valid length was not counted exactly once.")
    `CRC32FRC_ASSERT_NEXT(a_bad_length_not_counted, clk, rst_n,
        q_pop && q_entry.len_class != crc32frc_pkg::LEN_VALID,
        $stable(frames_reg) && $stable(errors_reg) && $stable(lost_reg),
        "Frame of bad length changed a counter.")

endmodule
